/* design/sfce_pkg.sv */
// shared types and constants for the frame checksum engine
`timescale 1ns / 1ps

package sfce_pkg;

  localparam logic [7:0] SYNC_A = 8'h55;
  localparam logic [7:0] SYNC_B = 8'hAA;

  localparam logic CFG_GENERATE_MODE = 1'b0;
  localparam logic CFG_MAX_PAYLOAD   = 1'b1;

  localparam logic [7:0] MAX_PAYLOAD_RESET = 8'hFF;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SYNC = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       frame_end;
    status_t    status;
    logic [7:0] command;
    logic       last;
  } result_t;

  localparam int unsigned MAX_RESULTS = 3;

  typedef struct packed {
    logic [1:0]                  cnt;
    result_t [MAX_RESULTS-1:0]   res;
  } group_t;

  typedef struct packed {
    logic       gen;
    logic [7:0] max_payload;
  } cfg_t;

endpackage

/* design/sfce_core.sv */
// frame parser, running sums and per-byte result group
`timescale 1ns / 1ps

module sfce_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  sfce_pkg::cfg_t    cfg,
  output sfce_pkg::group_t  grp
);

  typedef enum logic [2:0] {
    PH_HUNT_A,
    PH_HUNT_B,
    PH_CMD,
    PH_LEN,
    PH_PAY,
    PH_CHK_A,
    PH_CHK_B_OK,
    PH_CHK_B_BAD
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] sf_r, sf_nxt;
  logic [7:0] ss_r, ss_nxt;

  logic [7:0]      sf_acc, ss_acc, left_dec;
  sfce_pkg::result_t echo, blank;
  sfce_pkg::group_t  g;

  assign sf_acc   = sf_r + in_byte;
  assign ss_acc   = ss_r + sf_acc;
  assign left_dec = left_r - 8'd1;

  always_comb begin
    blank = '0;
    blank.status = sfce_pkg::ST_OK;
    echo = blank;
    echo.data_byte  = in_byte;
    echo.byte_valid = 1'b1;

    g = '0;
    g.res[0] = blank;
    g.res[1] = blank;
    g.res[2] = blank;
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    left_nxt  = left_r;
    sf_nxt    = sf_r;
    ss_nxt    = ss_r;

    case (phase_r)
      PH_HUNT_A: begin
        if (in_byte == sfce_pkg::SYNC_A) begin
          if (cfg.gen) begin
            g.res[0] = echo;
            g.cnt    = 2'd1;
          end
          phase_nxt = PH_HUNT_B;
        end
      end
      PH_HUNT_B: begin
        if (in_byte == sfce_pkg::SYNC_B) begin
          if (cfg.gen) begin
            g.res[0] = echo;
            g.cnt    = 2'd1;
          end
          phase_nxt = PH_CMD;
        end else begin
          g.res[0].frame_end = 1'b1;
          g.res[0].status    = sfce_pkg::ST_BAD_SYNC;
          g.cnt     = 2'd1;
          phase_nxt = PH_HUNT_A;
        end
      end
      PH_CMD: begin
        cmd_nxt = in_byte;
        sf_nxt  = in_byte;
        ss_nxt  = in_byte;
        if (cfg.gen) begin
          g.res[0] = echo;
          g.cnt    = 2'd1;
        end
        phase_nxt = PH_LEN;
      end
      PH_LEN, PH_PAY: begin
        if (phase_r == PH_LEN && in_byte > cfg.max_payload) begin
          g.res[0].frame_end = 1'b1;
          g.res[0].status    = sfce_pkg::ST_TOO_LONG;
          g.res[0].command   = cmd_r;
          g.cnt     = 2'd1;
          phase_nxt = PH_HUNT_A;
        end else begin
          sf_nxt   = sf_acc;
          ss_nxt   = ss_acc;
          left_nxt = (phase_r == PH_LEN) ? in_byte : left_dec;
          if (cfg.gen) begin
            g.res[0] = echo;
            g.cnt    = 2'd1;
          end
          if (left_nxt == 8'd0) begin
            if (cfg.gen) begin
              g.res[1].data_byte  = sf_acc;
              g.res[1].byte_valid = 1'b1;
              g.res[2].data_byte  = ss_acc;
              g.res[2].byte_valid = 1'b1;
              g.res[2].frame_end  = 1'b1;
              g.res[2].command    = cmd_r;
              g.cnt     = 2'd3;
              phase_nxt = PH_HUNT_A;
            end else begin
              phase_nxt = PH_CHK_A;
            end
          end else begin
            phase_nxt = PH_PAY;
          end
        end
      end
      PH_CHK_A: begin
        phase_nxt = (in_byte == sf_r) ? PH_CHK_B_OK : PH_CHK_B_BAD;
      end
      PH_CHK_B_OK, PH_CHK_B_BAD: begin
        g.res[0].frame_end = 1'b1;
        g.res[0].status    = (phase_r == PH_CHK_B_OK && in_byte == ss_r) ?
                             sfce_pkg::ST_OK : sfce_pkg::ST_MISMATCH;
        g.res[0].command   = cmd_r;
        g.cnt     = 2'd1;
        phase_nxt = PH_HUNT_A;
      end
      default: begin
        phase_nxt = PH_HUNT_A;
      end
    endcase

    // mark the final result of this byte
    for (int i = 0; i < sfce_pkg::MAX_RESULTS; i++) begin
      g.res[i].last = (g.cnt != 2'd0) && (2'(i) == g.cnt - 2'd1);
    end
  end

  assign grp = g;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT_A;
      cmd_r   <= '0;
      left_r  <= '0;
      sf_r    <= '0;
      ss_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      left_r  <= left_nxt;
      sf_r    <= sf_nxt;
      ss_r    <= ss_nxt;
    end
  end

  a_hunt_drop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == PH_HUNT_A && in_byte != sfce_pkg::SYNC_A |-> grp.cnt == 2'd0)
    else $error("stray byte while hunting produced a result");

  a_three_gen: assert property (@(posedge clk) disable iff (!rst_n)
    grp.cnt == 2'd3 |-> cfg.gen && grp.res[2].frame_end)
    else $error("appended check bytes outside generate mode");

  a_seed: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == PH_CMD |=> sf_r == cmd_r && ss_r == cmd_r)
    else $error("sums not seeded with command byte");

endmodule

/* design/sfce_outq.sv */
// result register that drains one byte's results one per cycle while out_stall is low
`timescale 1ns / 1ps

module sfce_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  sfce_pkg::group_t   grp,
  input  logic               out_stall,
  output logic               can_load,
  output logic               out_valid,
  output sfce_pkg::result_t  res
);

  logic [1:0]        cnt_r, cnt_nxt;
  sfce_pkg::result_t ent_r [sfce_pkg::MAX_RESULTS];
  sfce_pkg::result_t ent_nxt [sfce_pkg::MAX_RESULTS];
  logic              pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign can_load  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);
  assign res       = ent_r[0];

  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < sfce_pkg::MAX_RESULTS; i++) begin
      ent_nxt[i] = ent_r[i];
    end
    if (load) begin
      cnt_nxt = grp.cnt;
      for (int i = 0; i < sfce_pkg::MAX_RESULTS; i++) begin
        ent_nxt[i] = grp.res[i];
      end
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
      for (int i = 0; i < sfce_pkg::MAX_RESULTS - 1; i++) begin
        ent_nxt[i] = ent_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < sfce_pkg::MAX_RESULTS; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> can_load)
    else $error("result group loaded over pending results");

  a_last_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cnt_r == 2'd1 |-> res.last)
    else $error("final result of a byte lacks last");

  a_last_only_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cnt_r != 2'd1 |-> !res.last)
    else $error("last set before final result of a byte");

endmodule

/* design/sync_frame_checksum_engine_unit.sv */
// top level of the framed byte-stream checksum engine
//
//   channel  direction  handshake          payload
//   in_      request in  in_valid/in_stall  in_byte
//   out_     request out out_valid/out_stall data_byte, byte_valid, frame_end,
//                                           status, command, last
//   cfg_     write in    cfg_valid/cfg_ready cfg_index, cfg_data
//
// one input byte is taken per cycle while in_stall is low; its results
// appear the next cycle; a byte with several results (echo plus two check
// bytes) holds the input while the result register drains
// synchronous active-low reset returns the parser to sync hunting
// out_stall holds the current result; in_stall rises only while results wait
`timescale 1ns / 1ps

module sync_frame_checksum_engine_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_byte_valid,
  output logic       out_frame_end,
  output logic [1:0] out_status,
  output logic [7:0] out_command,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  sfce_pkg::cfg_t    cfg_r;
  sfce_pkg::group_t  grp;
  sfce_pkg::result_t res;
  logic              can_load;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = !can_load;
  assign accept    = in_valid && can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gen         <= 1'b0;
      cfg_r.max_payload <= sfce_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfce_pkg::CFG_GENERATE_MODE: cfg_r.gen         <= cfg_data[0];
        sfce_pkg::CFG_MAX_PAYLOAD:   cfg_r.max_payload <= cfg_data;
        default: ;
      endcase
    end
  end

  sfce_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .cfg     (cfg_r),
    .grp     (grp)
  );

  sfce_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .grp       (grp),
    .out_stall (out_stall),
    .can_load  (can_load),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_data_byte  = res.data_byte;
  assign out_byte_valid = res.byte_valid;
  assign out_frame_end  = res.frame_end;
  assign out_status     = res.status;
  assign out_command    = res.command;
  assign out_last       = res.last;

endmodule

/* tb/tb_sync_frame_checksum_engine_unit.sv */
// testbench for the frame checksum engine: directed and random byte streams against a predictor
`timescale 1ns / 1ps

module tb_sync_frame_checksum_engine_unit;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 360;
  localparam int DRAIN_CYCLES = 6;
  localparam int NO_SWITCH    = -1;

  typedef enum logic [2:0] {
    HUNT_SYNC_A,
    HUNT_SYNC_B,
    GET_CMD,
    GET_LEN,
    GET_PAYLOAD,
    GET_CHK_A,
    GET_CHK_B_OK,
    GET_CHK_B_BAD
  } parse_phase_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       out_stall = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_index = sfce_pkg::CFG_GENERATE_MODE;
  logic [7:0] cfg_data  = 8'h00;

  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_data_byte;
  logic       out_byte_valid;
  logic       out_frame_end;
  logic [1:0] out_status;
  logic [7:0] out_command;
  logic       out_last;
  logic       cfg_ready;

  sync_frame_checksum_engine_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_byte  (out_data_byte),
    .out_byte_valid (out_byte_valid),
    .out_frame_end  (out_frame_end),
    .out_status     (out_status),
    .out_command    (out_command),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state
  parse_phase_t exp_phase = HUNT_SYNC_A;
  logic         exp_gen   = 1'b0;
  logic [7:0]   exp_max   = sfce_pkg::MAX_PAYLOAD_RESET;
  logic [7:0]   exp_cmd   = 8'h00;
  logic [7:0]   exp_left  = 8'h00;
  logic [7:0]   exp_sum_a = 8'h00;
  logic [7:0]   exp_sum_b = 8'h00;

  sfce_pkg::result_t pending_results[$];
  sfce_pkg::result_t step_results[$];

  int error_count   = 0;
  int counted_bytes = 0;
  int cycle_count   = 0;
  int tx_calm       = 0;
  int rx_stall_left = 0;
  int rx_calm       = 0;

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic sfce_pkg::result_t make_result(logic [7:0] data, logic valid,
                                                    logic frame_done,
                                                    sfce_pkg::status_t st,
                                                    logic [7:0] cmd);
    sfce_pkg::result_t r;
    r.data_byte  = data;
    r.byte_valid = valid;
    r.frame_end  = frame_done;
    r.status     = st;
    r.command    = cmd;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic void echo_byte(logic [7:0] b);
    if (exp_gen)
      step_results.push_back(make_result(b, 1'b1, 1'b0, sfce_pkg::ST_OK, 8'h00));
  endfunction

  function automatic void add_to_sums(logic [7:0] b);
    exp_sum_a = exp_sum_a + b;
    exp_sum_b = exp_sum_b + exp_sum_a;
  endfunction

  // mode is taken at the end of the payload
  function automatic void close_payload();
    if (exp_gen) begin
      step_results.push_back(make_result(exp_sum_a, 1'b1, 1'b0, sfce_pkg::ST_OK, 8'h00));
      step_results.push_back(make_result(exp_sum_b, 1'b1, 1'b1, sfce_pkg::ST_OK, exp_cmd));
      exp_phase = HUNT_SYNC_A;
    end else begin
      exp_phase = GET_CHK_A;
    end
  endfunction

  task automatic predict_byte(input logic [7:0] b, output bit dropped);
    sfce_pkg::result_t r;
    bit                ok;
    dropped = 1'b0;
    step_results.delete();
    case (exp_phase)
      HUNT_SYNC_A: begin
        if (b == sfce_pkg::SYNC_A) begin
          echo_byte(b);
          exp_phase = HUNT_SYNC_B;
        end else begin
          dropped = 1'b1;
        end
      end
      HUNT_SYNC_B: begin
        if (b == sfce_pkg::SYNC_B) begin
          echo_byte(b);
          exp_phase = GET_CMD;
        end else begin
          step_results.push_back(make_result(8'h00, 1'b0, 1'b1, sfce_pkg::ST_BAD_SYNC,
                                             8'h00));
          exp_phase = HUNT_SYNC_A;
        end
      end
      GET_CMD: begin
        exp_cmd   = b;
        exp_sum_a = b;
        exp_sum_b = b;
        echo_byte(b);
        exp_phase = GET_LEN;
      end
      GET_LEN: begin
        if (b > exp_max) begin
          step_results.push_back(make_result(8'h00, 1'b0, 1'b1, sfce_pkg::ST_TOO_LONG,
                                             exp_cmd));
          exp_phase = HUNT_SYNC_A;
        end else begin
          add_to_sums(b);
          exp_left = b;
          echo_byte(b);
          if (b == 8'h00) close_payload();
          else exp_phase = GET_PAYLOAD;
        end
      end
      GET_PAYLOAD: begin
        add_to_sums(b);
        echo_byte(b);
        exp_left = exp_left - 8'h01;
        if (exp_left == 8'h00) close_payload();
      end
      GET_CHK_A: begin
        exp_phase = (b == exp_sum_a) ? GET_CHK_B_OK : GET_CHK_B_BAD;
      end
      default: begin
        ok = (exp_phase == GET_CHK_B_OK) && (b == exp_sum_b);
        step_results.push_back(make_result(8'h00, 1'b0, 1'b1,
                                           ok ? sfce_pkg::ST_OK : sfce_pkg::ST_MISMATCH,
                                           exp_cmd));
        exp_phase = HUNT_SYNC_A;
      end
    endcase
    foreach (step_results[i]) begin
      r      = step_results[i];
      r.last = (i == step_results.size() - 1);
      pending_results.push_back(r);
    end
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // result side
  always @(posedge clk) begin : result_check
    sfce_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: data_byte %0h frame_end %0b status %0d",
               out_data_byte, out_frame_end, out_status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("data_byte", want.data_byte, out_data_byte);
        check_field("byte_valid", 8'(want.byte_valid), 8'(out_byte_valid));
        check_field("frame_end", 8'(want.frame_end), 8'(out_frame_end));
        check_field("status", 8'(want.status), 8'(out_status));
        check_field("command", want.command, out_command);
        check_field("last", 8'(want.last), 8'(out_last));
      end
    end
  end

  always @(negedge clk) begin
    if (rx_stall_left > 0) begin
      out_stall <= 1'b1;
      rx_stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (rx_calm > 0) rx_calm--;
      else if ($urandom_range(0, 39) == 0) rx_calm = $urandom_range(20, 100);
      else if ($urandom_range(0, 3) == 0) rx_stall_left = pick_gap();
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_sync_frame_checksum_engine_unit: errors");
    $finish;
  end

  // one request on the byte channel; valid stays high when the next byte follows at once
  task automatic send_byte(input logic [7:0] b);
    bit dropped;
    int gap;
    in_byte  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b, dropped);
    if (!dropped) counted_bytes++;
    @(negedge clk);
    gap = 0;
    if (tx_calm > 0) tx_calm--;
    else if ($urandom_range(0, 29) == 0) tx_calm = $urandom_range(20, 80);
    else if ($urandom_range(0, 1) == 0) gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_byte  <= 8'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [7:0] value);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == sfce_pkg::CFG_GENERATE_MODE) exp_gen = value[0];
    else exp_max = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic toggle_mode();
    cfg_write(sfce_pkg::CFG_GENERATE_MODE, {7'd0, ~exp_gen});
  endtask

  task automatic send_frame(input logic [7:0] cmd, input int len, input bit bad_a,
                            input bit bad_b, input int switch_at);
    send_byte(sfce_pkg::SYNC_A);
    send_byte(sfce_pkg::SYNC_B);
    send_byte(cmd);
    send_byte(8'(len));
    for (int i = 0; i < len && exp_phase == GET_PAYLOAD; i++) begin
      if (i == switch_at) toggle_mode();
      send_byte(8'($urandom));
    end
    if (switch_at == len && exp_phase == GET_CHK_A) toggle_mode();
    if (exp_phase == GET_CHK_A)
      send_byte(exp_sum_a ^ (bad_a ? 8'($urandom_range(1, 255)) : 8'h00));
    if (exp_phase == GET_CHK_B_OK || exp_phase == GET_CHK_B_BAD)
      send_byte(exp_sum_b ^ (bad_b ? 8'($urandom_range(1, 255)) : 8'h00));
  endtask

  task automatic test_sync_hunting();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(sfce_pkg::SYNC_A);
    send_byte(sfce_pkg::SYNC_A);
    send_byte(sfce_pkg::SYNC_B);
  endtask

  task automatic test_check_mode();
    send_frame(8'hFF, 0, 1'b0, 1'b0, NO_SWITCH);
    send_frame(8'h00, 0, 1'b0, 1'b1, NO_SWITCH);
  endtask

  task automatic test_too_long();
    cfg_write(sfce_pkg::CFG_MAX_PAYLOAD, 8'h00);
    send_frame(8'h7E, 1, 1'b0, 1'b0, NO_SWITCH);
    cfg_write(sfce_pkg::CFG_MAX_PAYLOAD, sfce_pkg::MAX_PAYLOAD_RESET);
  endtask

  task automatic test_generate_mode();
    cfg_write(sfce_pkg::CFG_GENERATE_MODE, 8'h01);
    send_frame(8'h80, 1, 1'b0, 1'b0, NO_SWITCH);
  endtask

  task automatic test_mode_switch();
    send_frame(8'h5A, 2, 1'b0, 1'b0, 1);
    cfg_write(sfce_pkg::CFG_GENERATE_MODE, 8'h00);
    send_frame(8'hA5, 1, 1'b0, 1'b0, 1);
  endtask

  task automatic test_random_stream();
    int frames_left;
    int len;
    int kind;
    counted_bytes = 0;
    frames_left   = 0;
    while (counted_bytes < RANDOM_BYTES) begin
      if (frames_left == 0) begin
        cfg_write(sfce_pkg::CFG_GENERATE_MODE, 8'($urandom_range(0, 1)));
        case ($urandom_range(0, 4))
          0:       cfg_write(sfce_pkg::CFG_MAX_PAYLOAD, 8'h00);
          1:       cfg_write(sfce_pkg::CFG_MAX_PAYLOAD, 8'hFF);
          2:       cfg_write(sfce_pkg::CFG_MAX_PAYLOAD, 8'($urandom_range(1, 6)));
          default: cfg_write(sfce_pkg::CFG_MAX_PAYLOAD, 8'($urandom_range(0, 255)));
        endcase
        frames_left = $urandom_range(3, 8);
      end
      frames_left--;
      len  = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      kind = $urandom_range(0, 15);
      if (kind == 0) begin
        send_byte(8'($urandom));
      end else if (kind == 1) begin
        send_byte(sfce_pkg::SYNC_A);
        send_byte(8'($urandom));
      end else begin
        send_frame(8'($urandom), len, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                   (kind == 2) ? $urandom_range(0, len) : NO_SWITCH);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_sync_hunting();
    test_check_mode();
    test_too_long();
    test_generate_mode();
    test_mode_switch();
    test_random_stream();
    settle_block();
    if (error_count == 0) begin
      $display("tb_sync_frame_checksum_engine_unit: clean");
    end else begin
      $display("tb_sync_frame_checksum_engine_unit: errors");
    end
    $finish;
  end

endmodule
